// ===== sv/usbdcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package usbdcr_pkg;

    localparam int NUM_EP = 4;

    // item kinds carried in tuser
    typedef enum logic [2:0] {
        OP_READ       = 3'd0,
        OP_WRITE      = 3'd1,
        OP_BUS_RST_ON = 3'd2,
        OP_BUS_RST_OFF= 3'd3,
        OP_SETUP      = 3'd4,
        OP_PACKET     = 3'd5
    } op_t;

    // receive status codes
    localparam logic [1:0] RS_OK         = 2'd0;
    localparam logic [1:0] RS_NOT_PRIMED = 2'd1;
    localparam logic [1:0] RS_TOO_BIG    = 2'd2;
    localparam logic [1:0] RS_NONE       = 2'd3;

    // read widths
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    // register offsets
    localparam logic [8:0] OFF_ID         = 9'h000;
    localparam logic [8:0] OFF_HWGENERAL  = 9'h004;
    localparam logic [8:0] OFF_HWHOST     = 9'h008;
    localparam logic [8:0] OFF_HWDEVICE   = 9'h00C;
    localparam logic [8:0] OFF_HWTXBUF    = 9'h010;
    localparam logic [8:0] OFF_HWRXBUF    = 9'h014;
    localparam logic [8:0] OFF_GPTIMER0   = 9'h080;
    localparam logic [8:0] OFF_GPTIMER1   = 9'h084;
    localparam logic [8:0] OFF_CAPLENGTH  = 9'h100;
    localparam logic [8:0] OFF_HCIVERSION = 9'h102;
    localparam logic [8:0] OFF_HCSPARAMS  = 9'h104;
    localparam logic [8:0] OFF_HCCPARAMS  = 9'h108;
    localparam logic [8:0] OFF_HCRSVD     = 9'h10C;
    localparam logic [8:0] OFF_DCIVERSION = 9'h120;
    localparam logic [8:0] OFF_DCCPARAMS  = 9'h124;
    localparam logic [8:0] OFF_USBCMD     = 9'h140;
    localparam logic [8:0] OFF_USBSTS     = 9'h144;
    localparam logic [8:0] OFF_USBINTR    = 9'h148;
    localparam logic [8:0] OFF_DEVADDR    = 9'h154;
    localparam logic [8:0] OFF_EPLISTADDR = 9'h158;
    localparam logic [8:0] OFF_PORTSC     = 9'h184;
    localparam logic [8:0] OFF_OTGSC      = 9'h1A4;
    localparam logic [8:0] OFF_USBMODE    = 9'h1A8;
    localparam logic [8:0] OFF_EPSETUPSR  = 9'h1AC;
    localparam logic [8:0] OFF_EPPRIME    = 9'h1B0;
    localparam logic [8:0] OFF_EPFLUSH    = 9'h1B4;
    localparam logic [8:0] OFF_EPSTAT     = 9'h1B8;
    localparam logic [8:0] OFF_EPCOMPLETE = 9'h1BC;
    localparam logic [8:0] OFF_EPCTRL0    = 9'h1C0;
    localparam logic [8:0] OFF_EPCTRL1    = 9'h1C4;
    localparam logic [8:0] OFF_EPCTRL2    = 9'h1C8;
    localparam logic [8:0] OFF_EPCTRL3    = 9'h1CC;

    // fixed read values
    localparam logic [31:0] VAL_ID         = 32'h0042FA05;
    localparam logic [31:0] VAL_HWGENERAL  = 32'h000002C5;
    localparam logic [31:0] VAL_HWHOST     = 32'h10020001;
    localparam logic [31:0] VAL_HWDEVICE   = 32'h00000009;
    localparam logic [31:0] VAL_HWTXBUF    = 32'h80050708;
    localparam logic [31:0] VAL_HWRXBUF    = 32'h00000508;
    localparam logic [31:0] VAL_CAPLENGTH  = 32'h01000040;
    localparam logic [31:0] VAL_HCSPARAMS  = 32'h00010011;
    localparam logic [31:0] VAL_HCCPARAMS  = 32'h00000006;
    localparam logic [31:0] VAL_DCIVERSION = 32'h00000001;
    localparam logic [31:0] VAL_DCCPARAMS  = 32'h00000184;
    localparam logic [31:0] VAL_EPCTRL0    = 32'h00800080;
    localparam logic [31:0] VAL_CAP_BYTE   = 32'h00000040;
    localparam logic [31:0] VAL_HCI_HALF   = 32'h00000100;

    // masks and reset values
    localparam logic [31:0] INTR_MASK      = 32'h030101D7;
    localparam logic [31:0] OTG_WMASK      = 32'h7F00003B;
    localparam logic [31:0] OTG_W1C_MASK   = 32'h007F0000;
    localparam logic [31:0] PORT_RST_ON    = 32'h0C000100;
    localparam logic [31:0] CMD_RESET_VAL  = 32'h00080000;
    localparam logic [31:0] PORT_RESET_VAL = 32'hEC000004;
    localparam logic [30:0] OTG_RESET_VAL  = 31'h00000F20;

    typedef struct packed {
        logic [3:0]  tx_ioc_bits;
        logic        head_ios;
        logic        desc_ioc;
        logic [14:0] desc_max_len;
        logic [14:0] pkt_len;
        logic [1:0]  ep_index;
        logic [31:0] wdata;
        logic [1:0]  access_size;
        logic [8:0]  offset;
        logic [2:0]  op;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  tx_done_bits;
        logic [3:0]  rx_primed_bits;
        logic        irq;
        logic [1:0]  recv_status;
        logic        bad_access;
        logic [31:0] rdata;
    } res_item_t;

endpackage

`default_nettype wire

// ===== sv/usbdcr_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module usbdcr_in_stage
    import usbdcr_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_item,
    input  wire logic     advance,
    output logic          p_valid,
    output in_item_t      p_item
);

    logic     valid_reg;
    in_item_t item_reg;

    assign s_ready = !valid_reg || advance;
    assign p_valid = valid_reg;
    assign p_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/usbdcr_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module usbdcr_regs
    import usbdcr_pkg::*;
#(
    parameter int NUM_ENDPOINTS = NUM_EP
)
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     cfg_we,
    input  wire logic     cfg_wdata,
    input  wire logic     fire,
    input  wire in_item_t item,
    output res_item_t     result
);

    localparam int N = NUM_ENDPOINTS;

    logic         variant_cx_reg;
    logic [31:0]  cmd_reg,       cmd_next;
    logic [6:0]   status_reg,    status_next;
    logic [25:0]  intr_en_reg,   intr_en_next;
    logic [6:0]   dev_addr_reg,  dev_addr_next;
    logic [20:0]  list_base_reg, list_base_next;
    logic [31:0]  port_reg,      port_next;
    logic [30:0]  otg_reg,       otg_next;
    logic [N-1:0] setup_reg,     setup_next;
    logic [N-1:0] rx_primed_reg, rx_primed_next;
    logic [N-1:0] tx_primed_reg, tx_primed_next;
    logic [N-1:0] rx_done_reg,   rx_done_next;
    logic [N-1:0] tx_done_reg,   tx_done_next;

    logic [31:0]  wd;
    logic [15:0]  ep_onehot;
    logic [N-1:0] ep_bit;
    logic [N-1:0] rx_set;
    logic [N-1:0] tx_set;
    logic [15:0]  txioc16;
    logic [31:0]  otg_tmp;
    logic [31:0]  word;
    logic         word_hit;
    logic [31:0]  rdata;
    logic         bad;
    logic [1:0]   rstat;
    logic [N-1:0] rxp;
    logic [N-1:0] txd;
    logic [15:0]  rxp16;
    logic [15:0]  txd16;
    logic         irq;

    assign wd        = item.wdata;
    assign ep_onehot = 16'(1) << item.ep_index;
    assign ep_bit    = ep_onehot[N-1:0];
    assign rx_set    = wd[N-1:0];
    assign tx_set    = wd[16+N-1:16];
    assign txioc16   = 16'(item.tx_ioc_bits);

    // word read decode from current state
    always_comb begin
        word     = '0;
        word_hit = 1'b1;
        case (item.offset)
            OFF_ID:         word = VAL_ID;
            OFF_HWGENERAL:  word = VAL_HWGENERAL;
            OFF_HWHOST:     word = VAL_HWHOST;
            OFF_HWDEVICE:   word = VAL_HWDEVICE;
            OFF_HWTXBUF:    word = VAL_HWTXBUF;
            OFF_HWRXBUF:    word = VAL_HWRXBUF;
            OFF_CAPLENGTH:  word = VAL_CAPLENGTH;
            OFF_HCSPARAMS:  word = VAL_HCSPARAMS;
            OFF_HCCPARAMS:  word = VAL_HCCPARAMS;
            OFF_HCRSVD:     word = '0;
            OFF_DCIVERSION: word = VAL_DCIVERSION;
            OFF_DCCPARAMS:  word = VAL_DCCPARAMS;
            OFF_USBCMD:     word = cmd_reg;
            OFF_USBSTS:     word = 32'(status_reg);
            OFF_USBINTR:    word = 32'(intr_en_reg);
            OFF_DEVADDR:    word = {dev_addr_reg, 25'd0};
            OFF_EPLISTADDR: word = {list_base_reg, 11'd0};
            OFF_PORTSC:     word = port_reg;
            OFF_OTGSC:      word = {1'b0, otg_reg};
            OFF_USBMODE:    word_hit = variant_cx_reg;
            OFF_EPSETUPSR:  word = 32'(setup_reg);
            OFF_EPPRIME, OFF_EPFLUSH: word = '0;
            OFF_EPSTAT:     word = 32'(rx_primed_reg) | (32'(tx_primed_reg) << 16);
            OFF_EPCOMPLETE: word = 32'(rx_done_reg) | (32'(tx_done_reg) << 16);
            OFF_EPCTRL0:    word = VAL_EPCTRL0;
            OFF_EPCTRL1, OFF_EPCTRL2, OFF_EPCTRL3: word = '0;
            default:        word_hit = 1'b0;
        endcase
    end

    always_comb begin
        cmd_next       = cmd_reg;
        status_next    = status_reg;
        intr_en_next   = intr_en_reg;
        dev_addr_next  = dev_addr_reg;
        list_base_next = list_base_reg;
        port_next      = port_reg;
        otg_next       = otg_reg;
        setup_next     = setup_reg;
        rx_primed_next = rx_primed_reg;
        tx_primed_next = tx_primed_reg;
        rx_done_next   = rx_done_reg;
        tx_done_next   = tx_done_reg;
        rdata          = '0;
        bad            = 1'b0;
        rstat          = RS_NONE;
        rxp            = '0;
        txd            = '0;
        otg_tmp        = '0;

        case (op_t'(item.op))
            OP_READ: begin
                case (item.access_size)
                    SZ_BYTE: begin
                        if (item.offset == OFF_CAPLENGTH) rdata = VAL_CAP_BYTE;
                        else bad = 1'b1;
                    end
                    SZ_HALF: begin
                        if (item.offset == OFF_HCIVERSION) rdata = VAL_HCI_HALF;
                        else bad = 1'b1;
                    end
                    SZ_WORD: begin
                        if (word_hit) rdata = word;
                        else bad = 1'b1;
                    end
                    default: bad = 1'b1;
                endcase
            end
            OP_WRITE: begin
                case (item.offset)
                    OFF_GPTIMER0, OFF_GPTIMER1, OFF_PORTSC, OFF_USBMODE,
                    OFF_EPCTRL0, OFF_EPCTRL1, OFF_EPCTRL2, OFF_EPCTRL3: begin
                    end
                    OFF_USBCMD: begin
                        // command reset returns every register but variant_cx to its reset value
                        if (wd[1]) begin
                            cmd_next       = CMD_RESET_VAL;
                            status_next    = '0;
                            intr_en_next   = '0;
                            dev_addr_next  = '0;
                            list_base_next = '0;
                            port_next      = PORT_RESET_VAL;
                            otg_next       = OTG_RESET_VAL;
                            setup_next     = '0;
                            rx_primed_next = '0;
                            tx_primed_next = '0;
                            rx_done_next   = '0;
                            tx_done_next   = '0;
                        end else begin
                            cmd_next = wd;
                        end
                    end
                    OFF_USBSTS:     status_next    = status_reg & ~wd[6:0];
                    OFF_USBINTR:    intr_en_next   = wd[25:0] & INTR_MASK[25:0];
                    OFF_DEVADDR:    dev_addr_next  = wd[31:25];
                    OFF_EPLISTADDR: list_base_next = wd[31:11];
                    OFF_OTGSC: begin
                        otg_tmp  = ({1'b0, otg_reg} & ~OTG_WMASK) | (wd & OTG_WMASK);
                        otg_tmp  = otg_tmp & ~(wd & OTG_W1C_MASK);
                        otg_next = otg_tmp[30:0];
                    end
                    OFF_EPSETUPSR:  setup_next = setup_reg & ~rx_set;
                    OFF_EPPRIME: begin
                        // transmit primes complete at once
                        rx_primed_next = rx_primed_reg | rx_set;
                        tx_primed_next = tx_primed_reg & ~tx_set;
                        tx_done_next   = tx_done_reg | tx_set;
                        rxp            = rx_set;
                        txd            = tx_set;
                        if (|(tx_set & txioc16[N-1:0])) status_next[0] = 1'b1;
                    end
                    OFF_EPFLUSH: begin
                        rx_primed_next = rx_primed_reg & ~rx_set;
                        tx_primed_next = tx_primed_reg & ~tx_set;
                    end
                    OFF_EPCOMPLETE: begin
                        rx_done_next = rx_done_reg & ~rx_set;
                        tx_done_next = tx_done_reg & ~tx_set;
                    end
                    default: bad = 1'b1;
                endcase
            end
            OP_BUS_RST_ON: begin
                port_next      = (port_reg & ~32'd1) | PORT_RST_ON;
                dev_addr_next  = '0;
                status_next[6] = 1'b1;
                rx_primed_next = '0;
                tx_primed_next = '0;
            end
            OP_BUS_RST_OFF: begin
                port_next      = (port_reg & ~PORT_RST_ON) | 32'd1;
                status_next[2] = 1'b1;
            end
            OP_SETUP: begin
                setup_next = setup_reg | ep_bit;
                if (item.head_ios) status_next[0] = 1'b1;
            end
            OP_PACKET: begin
                if (!(|(rx_primed_reg & ep_bit))) begin
                    rstat = RS_NOT_PRIMED;
                end else if (item.pkt_len > item.desc_max_len) begin
                    rstat = RS_TOO_BIG;
                end else begin
                    rstat          = RS_OK;
                    rx_primed_next = rx_primed_reg & ~ep_bit;
                    rx_done_next   = rx_done_reg | ep_bit;
                    if (item.desc_ioc) status_next[0] = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign irq = (|(status_next & intr_en_next[6:0])) |
                 (|(otg_next[30:24] & otg_next[22:16]));
    assign rxp16 = 16'(rxp);
    assign txd16 = 16'(txd);

    always_comb begin
        result.rdata          = rdata;
        result.bad_access     = bad;
        result.recv_status    = rstat;
        result.irq            = irq;
        result.rx_primed_bits = rxp16[3:0];
        result.tx_done_bits   = txd16[3:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            variant_cx_reg <= 1'b0;
        end else if (cfg_we) begin
            variant_cx_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg       <= CMD_RESET_VAL;
            status_reg    <= '0;
            intr_en_reg   <= '0;
            dev_addr_reg  <= '0;
            list_base_reg <= '0;
            port_reg      <= PORT_RESET_VAL;
            otg_reg       <= OTG_RESET_VAL;
            setup_reg     <= '0;
            rx_primed_reg <= '0;
            tx_primed_reg <= '0;
            rx_done_reg   <= '0;
            tx_done_reg   <= '0;
        end else if (fire) begin
            cmd_reg       <= cmd_next;
            status_reg    <= status_next;
            intr_en_reg   <= intr_en_next;
            dev_addr_reg  <= dev_addr_next;
            list_base_reg <= list_base_next;
            port_reg      <= port_next;
            otg_reg       <= otg_next;
            setup_reg     <= setup_next;
            rx_primed_reg <= rx_primed_next;
            tx_primed_reg <= tx_primed_next;
            rx_done_reg   <= rx_done_next;
            tx_done_reg   <= tx_done_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/usbdcr_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module usbdcr_out_stage
    import usbdcr_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      load,
    input  wire res_item_t res_in,
    output logic           free,
    output logic           m_valid,
    input  wire logic      m_ready,
    output res_item_t      m_item
);

    logic      valid_reg;
    res_item_t res_reg;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_item  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    // hold the word until taken
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

endmodule

`default_nettype wire

// ===== sv/usb_device_controller_registers_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Bits  Contents
// s_axis   in   88    tdata: offset, access_size, wdata, ep_index, pkt_len,
//                     desc_max_len, desc_ioc, head_ios, tx_ioc_bits; tuser: op
// m_axis   out  48    tdata: rdata, bad_access, recv_status, irq,
//                     rx_primed_bits, tx_done_bits
// cfg      in   1     variant_cx, written when cfg_we is high
//
// One word per cycle sustained while m_axis_tready stays high.
// The word is decoded and the registers updated in one pass between the input
// register and the result register. Synchronous active-low reset restores all
// registers; a USBCMD write with bit 1 set does the same except variant_cx.
// A stalled result stage backs up into the input stage, then lowers s_axis_tready.

module usb_device_controller_registers_top
    import usbdcr_pkg::*;
#(
    parameter int NUM_ENDPOINTS = NUM_EP
)
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [8:0] offset, [10:9] access_size, [42:11] wdata, [44:43] ep_index,
    // [59:45] pkt_len, [74:60] desc_max_len, [75] desc_ioc, [76] head_ios,
    // [80:77] tx_ioc_bits, [87:81] zero
    input  wire logic [87:0] s_axis_tdata,
    // [2:0] op
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] rdata, [32] bad_access, [34:33] recv_status, [35] irq,
    // [39:36] rx_primed_bits, [43:40] tx_done_bits, [47:44] zero
    output logic [47:0]      m_axis_tdata
);

    in_item_t  s_item;
    in_item_t  p_item;
    res_item_t res;
    res_item_t m_item;
    logic      p_valid;
    logic      out_free;
    logic      advance;

    assign s_item.op           = s_axis_tuser;
    assign s_item.offset       = s_axis_tdata[8:0];
    assign s_item.access_size  = s_axis_tdata[10:9];
    assign s_item.wdata        = s_axis_tdata[42:11];
    assign s_item.ep_index     = s_axis_tdata[44:43];
    assign s_item.pkt_len      = s_axis_tdata[59:45];
    assign s_item.desc_max_len = s_axis_tdata[74:60];
    assign s_item.desc_ioc     = s_axis_tdata[75];
    assign s_item.head_ios     = s_axis_tdata[76];
    assign s_item.tx_ioc_bits  = s_axis_tdata[80:77];

    assign advance = p_valid && out_free;

    usbdcr_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_item  (s_item),
        .advance (advance),
        .p_valid (p_valid),
        .p_item  (p_item)
    );

    usbdcr_regs #(
        .NUM_ENDPOINTS (NUM_ENDPOINTS)
    ) u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (advance),
        .item      (p_item),
        .result    (res)
    );

    usbdcr_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance),
        .res_in  (res),
        .free    (out_free),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_item  (m_item)
    );

    assign m_axis_tdata = {4'd0, m_item.tx_done_bits, m_item.rx_primed_bits, m_item.irq,
                           m_item.recv_status, m_item.bad_access, m_item.rdata};

    // input stage full behind a stalled result must not take a word
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (p_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input stage accepts while full and stalled");

    // a receive result never carries a bus access outcome
    a_recv_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_item.recv_status != RS_NONE) |->
        (!m_item.bad_access && m_item.rdata == '0 &&
         m_item.rx_primed_bits == '0 && m_item.tx_done_bits == '0))
        else $error("receive result carries access fields");

    // an unhandled access returns zero data
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_item.bad_access) |-> (m_item.rdata == '0))
        else $error("unhandled access returns data");

endmodule

`default_nettype wire

// ===== bench/usb_device_controller_registers_top_tb.sv =====
`timescale 1ns / 1ps

module usb_device_controller_registers_top_tb;
    import usbdcr_pkg::*;

    // item kinds and read widths that the block must ignore or refuse
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;
    localparam logic [1:0] SZ_RSVD  = 2'd3;

    localparam logic [31:0] RX_BITS = (32'd1 << NUM_EP) - 32'd1;
    localparam logic [31:0] EP_BITS = RX_BITS | (RX_BITS << 16);

    // USBSTS bits touched by events
    localparam int STS_UI  = 0;
    localparam int STS_PCI = 2;
    localparam int STS_URI = 6;

    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 235;

    typedef struct packed {
        in_item_t  it;
        logic      typed_exp;
        res_item_t want;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    usb_device_controller_registers_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // register image kept alongside the block
    logic        mode_q;
    logic [31:0] cmd_q;
    logic [6:0]  sts_q;
    logic [31:0] intr_q;
    logic [6:0]  dev_q;
    logic [20:0] list_q;
    logic [31:0] port_q;
    logic [30:0] otg_q;
    logic [3:0]  setup_q;
    logic [31:0] primed_q;
    logic [31:0] done_q;

    res_item_t pending_results[$];
    int        errors = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;
    logic      hold_req = 1'b0;
    logic      hold_done = 1'b0;
    int        hold_left = 0;

    logic [8:0] reg_offs [0:31] = '{
        OFF_ID, OFF_HWGENERAL, OFF_HWHOST, OFF_HWDEVICE, OFF_HWTXBUF, OFF_HWRXBUF,
        OFF_GPTIMER0, OFF_GPTIMER1, OFF_CAPLENGTH, OFF_HCIVERSION, OFF_HCSPARAMS,
        OFF_HCCPARAMS, OFF_HCRSVD, OFF_DCIVERSION, OFF_DCCPARAMS, OFF_USBCMD,
        OFF_USBSTS, OFF_USBINTR, OFF_DEVADDR, OFF_EPLISTADDR, OFF_PORTSC, OFF_OTGSC,
        OFF_USBMODE, OFF_EPSETUPSR, OFF_EPPRIME, OFF_EPFLUSH, OFF_EPSTAT,
        OFF_EPCOMPLETE, OFF_EPCTRL0, OFF_EPCTRL1, OFF_EPCTRL2, OFF_EPCTRL3
    };

    function automatic void reset_regs();
        cmd_q    = CMD_RESET_VAL;
        sts_q    = '0;
        intr_q   = '0;
        dev_q    = '0;
        list_q   = '0;
        port_q   = PORT_RESET_VAL;
        otg_q    = OTG_RESET_VAL;
        setup_q  = '0;
        primed_q = '0;
        done_q   = '0;
    endfunction

    function automatic logic read_word(input logic [8:0] off, output logic [31:0] val);
        logic ok;
        ok = 1'b1;
        val = '0;
        case (off)
            OFF_ID:         val = VAL_ID;
            OFF_HWGENERAL:  val = VAL_HWGENERAL;
            OFF_HWHOST:     val = VAL_HWHOST;
            OFF_HWDEVICE:   val = VAL_HWDEVICE;
            OFF_HWTXBUF:    val = VAL_HWTXBUF;
            OFF_HWRXBUF:    val = VAL_HWRXBUF;
            OFF_CAPLENGTH:  val = VAL_CAPLENGTH;
            OFF_HCSPARAMS:  val = VAL_HCSPARAMS;
            OFF_HCCPARAMS:  val = VAL_HCCPARAMS;
            OFF_HCRSVD:     val = '0;
            OFF_DCIVERSION: val = VAL_DCIVERSION;
            OFF_DCCPARAMS:  val = VAL_DCCPARAMS;
            OFF_USBCMD:     val = cmd_q;
            OFF_USBSTS:     val = {25'd0, sts_q};
            OFF_USBINTR:    val = intr_q;
            OFF_DEVADDR:    val = {dev_q, 25'd0};
            OFF_EPLISTADDR: val = {list_q, 11'd0};
            OFF_PORTSC:     val = port_q;
            OFF_OTGSC:      val = {1'b0, otg_q};
            OFF_USBMODE:    ok = mode_q;
            OFF_EPSETUPSR:  val = {28'd0, setup_q};
            OFF_EPPRIME:    val = '0;
            OFF_EPFLUSH:    val = '0;
            OFF_EPSTAT:     val = primed_q;
            OFF_EPCOMPLETE: val = done_q;
            OFF_EPCTRL0:    val = VAL_EPCTRL0;
            OFF_EPCTRL1, OFF_EPCTRL2, OFF_EPCTRL3: val = '0;
            default:        ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic write_word(input logic [8:0] off, input logic [31:0] v,
                                        input logic [3:0] txioc,
                                        output logic [3:0] rxp, output logic [3:0] txd);
        logic        ok;
        logic [31:0] o;
        ok = 1'b1;
        rxp = '0;
        txd = '0;
        case (off)
            OFF_GPTIMER0, OFF_GPTIMER1, OFF_PORTSC, OFF_USBMODE: ;
            OFF_EPCTRL0, OFF_EPCTRL1, OFF_EPCTRL2, OFF_EPCTRL3: ;
            OFF_USBCMD: begin
                if (v[1]) begin
                    reset_regs();
                end else begin
                    cmd_q = v;
                end
            end
            OFF_USBSTS:     sts_q = sts_q & ~v[6:0];
            OFF_USBINTR:    intr_q = v & INTR_MASK;
            OFF_DEVADDR:    dev_q = v[31:25];
            OFF_EPLISTADDR: list_q = v[31:11];
            OFF_OTGSC: begin
                // W1C status bits clear after the plain update
                o = {1'b0, otg_q};
                o = (o & ~OTG_WMASK) | (v & OTG_WMASK);
                o = o & ~(v & OTG_W1C_MASK);
                otg_q = o[30:0];
            end
            OFF_EPSETUPSR:  setup_q = setup_q & ~v[3:0];
            OFF_EPPRIME: begin
                for (int e = 0; e < NUM_EP; e++) begin
                    if (v[e]) begin
                        primed_q[e] = 1'b1;
                        rxp[e] = 1'b1;
                    end
                    // transmit completes the moment it is primed
                    if (v[16 + e]) begin
                        primed_q[16 + e] = 1'b0;
                        done_q[16 + e] = 1'b1;
                        txd[e] = 1'b1;
                        if (txioc[e]) sts_q[STS_UI] = 1'b1;
                    end
                end
            end
            OFF_EPFLUSH:    primed_q = primed_q & ~v & EP_BITS;
            OFF_EPCOMPLETE: done_q = done_q & ~v & EP_BITS;
            default:        ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic res_item_t apply_item(input in_item_t it);
        res_item_t   r;
        logic [31:0] val;
        logic [3:0]  rxp;
        logic [3:0]  txd;
        int          ep;
        r = '0;
        r.recv_status = RS_NONE;
        ep = int'(it.ep_index);
        case (it.op)
            OP_READ: begin
                case (it.access_size)
                    SZ_BYTE: begin
                        if (it.offset == OFF_CAPLENGTH) r.rdata = VAL_CAP_BYTE;
                        else r.bad_access = 1'b1;
                    end
                    SZ_HALF: begin
                        if (it.offset == OFF_HCIVERSION) r.rdata = VAL_HCI_HALF;
                        else r.bad_access = 1'b1;
                    end
                    SZ_WORD: begin
                        if (read_word(it.offset, val)) r.rdata = val;
                        else r.bad_access = 1'b1;
                    end
                    default: r.bad_access = 1'b1;
                endcase
            end
            OP_WRITE: begin
                r.bad_access = !write_word(it.offset, it.wdata, it.tx_ioc_bits, rxp, txd);
                r.rx_primed_bits = rxp;
                r.tx_done_bits = txd;
            end
            OP_BUS_RST_ON: begin
                port_q = (port_q & ~32'd1) | PORT_RST_ON;
                dev_q = '0;
                sts_q[STS_URI] = 1'b1;
                primed_q = '0;
            end
            OP_BUS_RST_OFF: begin
                port_q = (port_q & ~PORT_RST_ON) | 32'd1;
                sts_q[STS_PCI] = 1'b1;
            end
            OP_SETUP: begin
                setup_q[ep] = 1'b1;
                if (it.head_ios) sts_q[STS_UI] = 1'b1;
            end
            OP_PACKET: begin
                if (!primed_q[ep]) begin
                    r.recv_status = RS_NOT_PRIMED;
                end else if (it.pkt_len > it.desc_max_len) begin
                    r.recv_status = RS_TOO_BIG;
                end else begin
                    r.recv_status = RS_OK;
                    primed_q[ep] = 1'b0;
                    done_q[ep] = 1'b1;
                    if (it.desc_ioc) sts_q[STS_UI] = 1'b1;
                end
            end
            default: ;
        endcase
        r.irq = (|(sts_q & intr_q[6:0])) | (|(otg_q[30:24] & otg_q[22:16]));
        return r;
    endfunction

    function automatic in_item_t rand_item();
        in_item_t    it;
        logic [95:0] bits;
        logic [14:0] tmp;
        int unsigned pick;
        int unsigned sel;
        bits = {$urandom, $urandom, $urandom};
        it = bits[83:0];
        pick = $urandom_range(0, 99);
        if (pick < 28) begin
            it.op = OP_READ;
            if ($urandom_range(0, 4) != 0) it.access_size = SZ_WORD;
            if ($urandom_range(0, 7) != 0) it.offset = reg_offs[$urandom_range(0, 31)];
            if (it.access_size == SZ_BYTE && $urandom_range(0, 1) == 0)
                it.offset = OFF_CAPLENGTH;
            if (it.access_size == SZ_HALF && $urandom_range(0, 1) == 0)
                it.offset = OFF_HCIVERSION;
        end else if (pick < 58) begin
            it.op = OP_WRITE;
            sel = $urandom_range(0, 9);
            if (sel < 3) it.offset = OFF_EPPRIME;
            else if (sel == 3) it.offset = OFF_USBINTR;
            else if (sel > 4) it.offset = reg_offs[$urandom_range(0, 31)];
            // keep command resets rare so state can build up
            if (it.offset == OFF_USBCMD && $urandom_range(0, 15) != 0) it.wdata[1] = 1'b0;
        end else if (pick < 61) begin
            it.op = OP_BUS_RST_ON;
        end else if (pick < 64) begin
            it.op = OP_BUS_RST_OFF;
        end else if (pick < 74) begin
            it.op = OP_SETUP;
        end else if (pick < 98) begin
            it.op = OP_PACKET;
            if ($urandom_range(0, 3) != 0 && it.pkt_len > it.desc_max_len) begin
                tmp = it.pkt_len;
                it.pkt_len = it.desc_max_len;
                it.desc_max_len = tmp;
            end
        end else begin
            it.op = ($urandom_range(0, 1) != 0) ? OP_RSVD7 : OP_RSVD6;
        end
        return it;
    endfunction

    function automatic dir_row_t row(input logic [2:0] op, input logic [8:0] off,
                                     input logic [1:0] size, input logic [31:0] wdata,
                                     input logic [1:0] ep, input logic [14:0] plen,
                                     input logic [14:0] dmax, input logic dioc,
                                     input logic hios, input logic [3:0] txioc,
                                     input logic typed_exp, input logic [31:0] rdata,
                                     input logic bad, input logic [1:0] rs);
        dir_row_t d;
        d.it.op = op;
        d.it.offset = off;
        d.it.access_size = size;
        d.it.wdata = wdata;
        d.it.ep_index = ep;
        d.it.pkt_len = plen;
        d.it.desc_max_len = dmax;
        d.it.desc_ioc = dioc;
        d.it.head_ios = hios;
        d.it.tx_ioc_bits = txioc;
        d.typed_exp = typed_exp;
        d.want = '0;
        d.want.rdata = rdata;
        d.want.bad_access = bad;
        d.want.recv_status = rs;
        return d;
    endfunction

    task automatic send_word(input in_item_t it, input logic typed_exp, input res_item_t want);
        res_item_t r;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {7'd0, it.tx_ioc_bits, it.head_ios, it.desc_ioc, it.desc_max_len,
                          it.pkt_len, it.ep_index, it.wdata, it.access_size, it.offset};
        do @(posedge aclk); while (!s_axis_tready);
        r = apply_item(it);
        pending_results.push_back(typed_exp ? want : r);
    endtask

    task automatic settle();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_mode(input logic v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        mode_q = v;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // result side: random stalls, plus one long hold-off to back up the pipe
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        res_item_t want;
        res_item_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[43:0];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("rdata", want.rdata, got.rdata);
                check_field("bad_access", 32'(want.bad_access), 32'(got.bad_access));
                check_field("recv_status", 32'(want.recv_status), 32'(got.recv_status));
                check_field("irq", 32'(want.irq), 32'(got.irq));
                check_field("rx_primed_bits", 32'(want.rx_primed_bits),
                            32'(got.rx_primed_bits));
                check_field("tx_done_bits", 32'(want.tx_done_bits), 32'(got.tx_done_bits));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        dir_row_t rows[$];
        int       idle_tab [0:3];
        int       stall_tab [0:3];
        idle_tab  = '{0, 49, 0, 30};
        stall_tab = '{0, 0, 49, 30};

        // reads straight after reset have fixed answers
        rows.push_back(row(OP_READ, OFF_ID, SZ_WORD, '0, '0, '0, '0, '0, '0, '0,
                           1'b1, VAL_ID, 1'b0, RS_NONE));
        rows.push_back(row(OP_READ, OFF_CAPLENGTH, SZ_BYTE, '0, '0, '0, '0, '0, '0, '0,
                           1'b1, VAL_CAP_BYTE, 1'b0, RS_NONE));
        rows.push_back(row(OP_READ, OFF_HCIVERSION, SZ_HALF, '0, '0, '0, '0, '0, '0, '0,
                           1'b1, VAL_HCI_HALF, 1'b0, RS_NONE));
        rows.push_back(row(OP_READ, 9'h1FF, SZ_WORD, '0, '0, '0, '0, '0, '0, '0,
                           1'b1, '0, 1'b1, RS_NONE));
        rows.push_back(row(OP_READ, OFF_ID, SZ_RSVD, '0, '0, '0, '0, '0, '0, '0,
                           1'b1, '0, 1'b1, RS_NONE));
        rows.push_back(row(OP_READ, OFF_USBMODE, SZ_WORD, '0, '0, '0, '0, '0, '0, '0,
                           1'b1, '0, 1'b1, RS_NONE));
        rows.push_back(row(OP_READ, OFF_USBCMD, SZ_WORD, '0, '0, '0, '0, '0, '0, '0,
                           1'b1, CMD_RESET_VAL, 1'b0, RS_NONE));
        rows.push_back(row(OP_READ, OFF_PORTSC, SZ_WORD, '0, '0, '0, '0, '0, '0, '0,
                           1'b1, PORT_RESET_VAL, 1'b0, RS_NONE));
        // write width is ignored
        rows.push_back(row(OP_WRITE, OFF_USBINTR, SZ_BYTE, 32'hFFFF_FFFF, '0, '0, '0, '0,
                           '0, '0, 1'b0, '0, 1'b0, RS_NONE));
        rows.push_back(row(OP_BUS_RST_ON, '0, '0, '0, '0, '0, '0, '0, '0, '0,
                           1'b0, '0, 1'b0, RS_NONE));
        rows.push_back(row(OP_BUS_RST_OFF, '0, '0, '0, '0, '0, '0, '0, '0, '0,
                           1'b0, '0, 1'b0, RS_NONE));
        rows.push_back(row(OP_SETUP, '0, '0, '0, 2'd3, '0, '0, '0, 1'b1, '0,
                           1'b0, '0, 1'b0, RS_NONE));
        rows.push_back(row(OP_WRITE, OFF_EPPRIME, SZ_RSVD, 32'h000F_000F, '0, '0, '0, '0,
                           '0, 4'hF, 1'b0, '0, 1'b0, RS_NONE));
        rows.push_back(row(OP_PACKET, 9'h1FF, SZ_RSVD, 32'hFFFF_FFFF, '0, 15'h7FFF,
                           15'h7FFE, 1'b1, 1'b1, 4'hF, 1'b0, '0, 1'b0, RS_NONE));
        rows.push_back(row(OP_PACKET, '0, '0, '0, '0, '0, 15'h7FFF, 1'b1, '0, '0,
                           1'b0, '0, 1'b0, RS_NONE));
        rows.push_back(row(OP_PACKET, '0, '0, '0, '0, '0, '0, '0, '0, '0,
                           1'b0, '0, 1'b0, RS_NONE));
        rows.push_back(row(OP_WRITE, OFF_OTGSC, SZ_WORD, 32'hFFFF_FFFF, '0, '0, '0, '0, '0,
                           '0, 1'b0, '0, 1'b0, RS_NONE));
        rows.push_back(row(OP_READ, OFF_OTGSC, SZ_WORD, '0, '0, '0, '0, '0, '0, '0,
                           1'b0, '0, 1'b0, RS_NONE));
        rows.push_back(row(OP_RSVD7, 9'h1FF, SZ_RSVD, 32'hFFFF_FFFF, 2'd3, 15'h7FFF,
                           15'h7FFF, 1'b1, 1'b1, 4'hF, 1'b0, '0, 1'b0, RS_NONE));
        rows.push_back(row(OP_WRITE, OFF_ID, SZ_WORD, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0,
                           1'b0, '0, 1'b0, RS_NONE));
        rows.push_back(row(OP_WRITE, OFF_USBSTS, SZ_WORD, 32'hFFFF_FFFF, '0, '0, '0, '0,
                           '0, '0, 1'b0, '0, 1'b0, RS_NONE));
        rows.push_back(row(OP_WRITE, OFF_DEVADDR, SZ_WORD, 32'hFFFF_FFFF, '0, '0, '0, '0,
                           '0, '0, 1'b0, '0, 1'b0, RS_NONE));
        rows.push_back(row(OP_READ, OFF_DEVADDR, SZ_WORD, '0, '0, '0, '0, '0, '0, '0,
                           1'b0, '0, 1'b0, RS_NONE));
        // command reset, then EPSTAT reads back as after reset
        rows.push_back(row(OP_WRITE, OFF_USBCMD, SZ_WORD, 32'h0000_0002, '0, '0, '0, '0,
                           '0, '0, 1'b0, '0, 1'b0, RS_NONE));
        rows.push_back(row(OP_READ, OFF_EPSTAT, SZ_WORD, '0, '0, '0, '0, '0, '0, '0,
                           1'b1, '0, 1'b0, RS_NONE));

        mode_q = 1'b0;
        reset_regs();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) send_word(rows[i].it, rows[i].typed_exp, rows[i].want);
        s_axis_tvalid <= 1'b0;
        settle();

        for (int p = 0; p < 4; p++) begin
            write_mode(p % 2 == 0);
            idle_pct = idle_tab[p];
            stall_pct = stall_tab[p];
            if (p == 0) hold_req <= 1'b1;
            repeat (PHASE_ITEMS) send_word(rand_item(), 1'b0, '0);
            s_axis_tvalid <= 1'b0;
            settle();
        end

        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/usbdcr_pkg.sv
sv/usbdcr_in_stage.sv
sv/usbdcr_regs.sv
sv/usbdcr_out_stage.sv
sv/usb_device_controller_registers_top.sv
bench/usb_device_controller_registers_top_tb.sv
